// ===== src/dual_axis_dda_step_generator_defines.svh =====
// Assertion macros for the checker file of the dual-axis step generator.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef DUAL_AXIS_DDA_STEP_GENERATOR_DEFINES_SVH
`define DUAL_AXIS_DDA_STEP_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DADS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("step generator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DADS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("step generator check failed");

`endif

// ===== src/dads_pkg.sv =====
// Shared widths, codes and word types of the dual-axis step generator.
// Depends on nothing.
package dads_pkg;

  localparam int unsigned STEP_WIDTH     = 24;
  localparam int unsigned INTERVAL_WIDTH = 20;

  typedef enum logic [0:0] {
    FUNC_START = 1'b0,
    FUNC_TICK  = 1'b1
  } func_e;

  typedef struct packed {
    func_e                             func;
    logic signed [STEP_WIDTH-1:0]      delta_a;
    logic signed [STEP_WIDTH-1:0]      delta_b;
    logic        [INTERVAL_WIDTH-1:0]  interval_ticks;
    logic                              hold;
  } in_word_t;

  typedef struct packed {
    logic step_a;
    logic step_b;
    logic dir_a;
    logic dir_b;
    logic busy_res;
    logic paused;
    logic move_done;
    logic rejected;
  } out_word_t;

endpackage

// ===== src/dads_if.sv =====
// Valid/ready channel interfaces for input and result words.
// Depends on dads_pkg.
interface dads_in_if;
  logic               valid;
  logic               ready;
  dads_pkg::in_word_t data;

  modport source  (output valid, output data, input ready);
  modport sink    (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

interface dads_out_if;
  logic                valid;
  logic                ready;
  dads_pkg::out_word_t data;

  modport source  (output valid, output data, input ready);
  modport sink    (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

// ===== src/dual_axis_dda_step_generator.sv =====
// Top level of the two-axis DDA step pulse generator.
// Depends on dads_pkg, dads_if, dads_core and dads_out_reg.
//
//   Channel  Direction  Word        Accepted when
//   in_i     input      in_word_t   in_i.valid  && in_i.ready
//   out_o    output     out_word_t  out_o.valid && out_o.ready
//
// Every input word yields exactly one result word, in the cycle after it is taken.
// A word is taken in every cycle that the result register can take one; the move
// state and the result are computed in the same cycle, ahead of the result register.
// Reset (rst_ni low) ends any move and restores both directions to forward.
// When the result register holds a word that is not taken, in_i.ready drops
// and the move state is frozen until the word leaves.
module dual_axis_dda_step_generator (
  input logic        clk_i,
  input logic        rst_ni,
  dads_in_if.sink    in_i,
  dads_out_if.source out_o
);
  import dads_pkg::*;

  logic      accept;
  logic      stage_ready;
  out_word_t result;

  // The input side is ready whenever the result register can take a word.
  assign in_i.ready = stage_ready;
  assign accept     = in_i.valid & stage_ready;

  // Move state: start decoding, the DDA accumulators and the tick countdown.
  dads_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .word_i   (in_i.data),
    .result_o (result)
  );

  // One result word per accepted input word, held until the sink takes it.
  dads_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .data_i  (result),
    .ready_o (stage_ready),
    .valid_o (out_o.valid),
    .data_o  (out_o.data),
    .ready_i (out_o.ready)
  );

endmodule

// ===== src/dads_core.sv =====
// Move state and per-word next-state logic of the step generator.
// Depends on dads_pkg.
module dads_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  dads_pkg::in_word_t  word_i,
  output dads_pkg::out_word_t result_o
);
  import dads_pkg::*;

  logic                      active_q, active_d;
  logic                      dir_a_q, dir_a_d;
  logic                      dir_b_q, dir_b_d;
  logic [STEP_WIDTH-1:0]     mag_a_q, mag_a_d;
  logic [STEP_WIDTH-1:0]     mag_b_q, mag_b_d;
  logic [STEP_WIDTH-1:0]     total_q, total_d;
  logic [STEP_WIDTH:0]       err_a_q, err_a_d;
  logic [STEP_WIDTH:0]       err_b_q, err_b_d;
  logic [STEP_WIDTH-1:0]     steps_q, steps_d;
  logic [INTERVAL_WIDTH-1:0] count_q, count_d;
  logic [INTERVAL_WIDTH-1:0] ivl_q, ivl_d;

  logic                      neg_a, neg_b;
  logic [STEP_WIDTH-1:0]     new_mag_a, new_mag_b, new_total;
  logic [STEP_WIDTH:0]       sum_a, sum_b, total_ext;
  logic                      hit_a, hit_b;
  logic [STEP_WIDTH-1:0]     steps_inc;

  // Magnitudes of the start deltas; the most negative value maps to 2^(W-1).
  assign neg_a     = word_i.delta_a[STEP_WIDTH-1];
  assign neg_b     = word_i.delta_b[STEP_WIDTH-1];
  assign new_mag_a = neg_a ? (~word_i.delta_a + 1'b1) : word_i.delta_a;
  assign new_mag_b = neg_b ? (~word_i.delta_b + 1'b1) : word_i.delta_b;
  assign new_total = (new_mag_a > new_mag_b) ? new_mag_a : new_mag_b;

  // One DDA loop step per axis: add, compare against the total, subtract.
  assign total_ext = {1'b0, total_q};
  assign sum_a     = err_a_q + {1'b0, mag_a_q};
  assign sum_b     = err_b_q + {1'b0, mag_b_q};
  assign hit_a     = (sum_a >= total_ext);
  assign hit_b     = (sum_b >= total_ext);
  assign steps_inc = steps_q + 1'b1;

  always_comb begin
    active_d = active_q;
    dir_a_d  = dir_a_q;
    dir_b_d  = dir_b_q;
    mag_a_d  = mag_a_q;
    mag_b_d  = mag_b_q;
    total_d  = total_q;
    err_a_d  = err_a_q;
    err_b_d  = err_b_q;
    steps_d  = steps_q;
    count_d  = count_q;
    ivl_d    = ivl_q;
    result_o = '0;

    case (word_i.func)
      FUNC_START: begin
        if (active_q) begin
          result_o.rejected = 1'b1;
        end else if (new_total != '0) begin
          mag_a_d  = new_mag_a;
          mag_b_d  = new_mag_b;
          dir_a_d  = ~neg_a;
          dir_b_d  = ~neg_b;
          total_d  = new_total;
          err_a_d  = '0;
          err_b_d  = '0;
          steps_d  = '0;
          count_d  = '0;
          ivl_d    = (word_i.interval_ticks == '0) ? INTERVAL_WIDTH'(1)
                                                   : word_i.interval_ticks;
          active_d = 1'b1;
        end
      end
      FUNC_TICK: begin
        if (active_q) begin
          if (word_i.hold) begin
            result_o.paused = 1'b1;
          end else if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end else begin
            result_o.step_a = hit_a;
            result_o.step_b = hit_b;
            err_a_d = hit_a ? (sum_a - total_ext) : sum_a;
            err_b_d = hit_b ? (sum_b - total_ext) : sum_b;
            steps_d = steps_inc;
            count_d = ivl_q - 1'b1;
            if (steps_inc >= total_q) begin
              active_d           = 1'b0;
              result_o.move_done = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    result_o.dir_a    = dir_a_d;
    result_o.dir_b    = dir_b_d;
    result_o.busy_res = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      dir_a_q  <= 1'b1;
      dir_b_q  <= 1'b1;
      mag_a_q  <= '0;
      mag_b_q  <= '0;
      total_q  <= '0;
      err_a_q  <= '0;
      err_b_q  <= '0;
      steps_q  <= '0;
      count_q  <= '0;
      ivl_q    <= INTERVAL_WIDTH'(1);
    end else if (accept_i) begin
      active_q <= active_d;
      dir_a_q  <= dir_a_d;
      dir_b_q  <= dir_b_d;
      mag_a_q  <= mag_a_d;
      mag_b_q  <= mag_b_d;
      total_q  <= total_d;
      err_a_q  <= err_a_d;
      err_b_q  <= err_b_d;
      steps_q  <= steps_d;
      count_q  <= count_d;
      ivl_q    <= ivl_d;
    end
  end

endmodule

// ===== src/dads_out_reg.sv =====
// Result register that decouples the result channel from the input side.
// Depends on dads_pkg.
module dads_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  dads_pkg::out_word_t data_i,
  output logic                ready_o,
  output logic                valid_o,
  output dads_pkg::out_word_t data_o,
  input  logic                ready_i
);
  import dads_pkg::*;

  logic      valid_q, valid_d;
  out_word_t data_q;
  logic      load;

  // A new word may enter whenever the register is empty or is being drained.
  assign ready_o = ~valid_q | ready_i;
  assign load    = valid_i & ready_o;
  assign valid_d = load | (valid_q & ~ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== src/dads_checker.sv =====
// Port-level checks of the step generator, bound to its top level.
// Depends on dads_pkg and the assertion macro header.
`include "dual_axis_dda_step_generator_defines.svh"

module dads_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input dads_pkg::out_word_t out_data_i
);

  logic stepped;
  logic busy_or_held;

  assign stepped      = out_data_i.step_a | out_data_i.step_b;
  assign busy_or_held = out_data_i.busy_res | out_data_i.paused;

  // A stalled result word stays put.
  `DADS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))
  // With an empty result register the block always takes a word.
  `DADS_ASSERT_IMPL(a_ready_empty, !out_valid_i, in_ready_i)
  // A rejected start means a move was still running.
  `DADS_ASSERT_IMPL(a_reject_busy, out_valid_i && out_data_i.rejected, out_data_i.busy_res)
  // The final loop step ends the move.
  `DADS_ASSERT_IMPL(a_done_idle, out_valid_i && out_data_i.move_done, !busy_or_held)
  // A held tick never steps a motor.
  `DADS_ASSERT_IMPL(a_pause_nostep, out_valid_i && out_data_i.paused, !stepped && out_data_i.busy_res)

endmodule

bind dual_axis_dda_step_generator dads_checker u_dads_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the two-axis DDA step generator.
// Depends on dads_pkg, dads_if and the dual_axis_dda_step_generator RTL.

module tb_top;
  import dads_pkg::*;

  // Cycles with no word moving on either channel before the run is abandoned.
  // Random stalls are drawn per cycle, so long silent stretches only come from
  // a hang.
  localparam int unsigned STALL_LIMIT = 2000;

  typedef logic [STEP_WIDTH-1:0] mag_t;

  // Predicted state of the move engine, kept at the block's own widths.
  typedef struct {
    bit                        active;
    bit                        dir_a;
    bit                        dir_b;
    mag_t                      mag_a;
    mag_t                      mag_b;
    mag_t                      span;
    logic [STEP_WIDTH:0]       acc_a;
    logic [STEP_WIDTH:0]       acc_b;
    mag_t                      steps;
    logic [INTERVAL_WIDTH-1:0] wait_cnt;
    logic [INTERVAL_WIDTH-1:0] period;
  } motion_t;

  logic clk_i;
  logic rst_ni;

  dads_in_if  in_ch ();
  dads_out_if out_ch ();

  dual_axis_dda_step_generator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  motion_t   motion;
  out_word_t pending_steps [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int stall_cycles   = 0;
  int words_sent     = 0;

  // Names of the result fields, indexed by bit position in out_word_t.
  string field_names [8] = '{"rejected", "move_done", "paused", "busy_res",
                             "dir_b", "dir_a", "step_b", "step_a"};

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // The result side stalls at random; the rate is set by each test phase.
  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  task automatic reset_motion;
    motion.active   = 1'b0;
    motion.dir_a    = 1'b1;
    motion.dir_b    = 1'b1;
    motion.mag_a    = '0;
    motion.mag_b    = '0;
    motion.span     = '0;
    motion.acc_a    = '0;
    motion.acc_b    = '0;
    motion.steps    = '0;
    motion.wait_cnt = '0;
    motion.period   = INTERVAL_WIDTH'(1);
  endtask

  // Two's complement magnitude. The most negative delta maps to 2^(W-1),
  // which still fits the unsigned width.
  function automatic mag_t axis_magnitude(input logic signed [STEP_WIDTH-1:0] delta);
    mag_t raw;
    raw = delta;
    return raw[STEP_WIDTH-1] ? mag_t'(~raw + 1'b1) : raw;
  endfunction

  // Advances the predicted move by one input word and returns the result word
  // that the block must produce for it.
  function automatic out_word_t predict_step(input in_word_t w);
    out_word_t r;
    mag_t      ma;
    mag_t      mb;
    mag_t      top;
    r = '0;
    if (w.func == FUNC_START) begin
      if (motion.active) begin
        r.rejected = 1'b1;
      end else begin
        ma  = axis_magnitude(w.delta_a);
        mb  = axis_magnitude(w.delta_b);
        top = (ma > mb) ? ma : mb;
        // A move with nothing to do leaves even the directions alone.
        if (top != 0) begin
          motion.mag_a    = ma;
          motion.mag_b    = mb;
          motion.dir_a    = !w.delta_a[STEP_WIDTH-1];
          motion.dir_b    = !w.delta_b[STEP_WIDTH-1];
          motion.span     = top;
          motion.acc_a    = '0;
          motion.acc_b    = '0;
          motion.steps    = '0;
          motion.wait_cnt = '0;
          motion.period   = (w.interval_ticks == 0) ? INTERVAL_WIDTH'(1)
                                                    : w.interval_ticks;
          motion.active   = 1'b1;
        end
      end
    end else if (motion.active) begin
      if (w.hold) begin
        r.paused = 1'b1;
      end else if (motion.wait_cnt != 0) begin
        motion.wait_cnt = motion.wait_cnt - 1'b1;
      end else begin
        // Loop step: both accumulators advance, each axis steps on overflow.
        motion.acc_a = motion.acc_a + motion.mag_a;
        motion.acc_b = motion.acc_b + motion.mag_b;
        if (motion.acc_a >= motion.span) begin
          r.step_a     = 1'b1;
          motion.acc_a = motion.acc_a - motion.span;
        end
        if (motion.acc_b >= motion.span) begin
          r.step_b     = 1'b1;
          motion.acc_b = motion.acc_b - motion.span;
        end
        motion.steps    = motion.steps + 1'b1;
        motion.wait_cnt = motion.period - 1'b1;
        if (motion.steps >= motion.span) begin
          motion.active = 1'b0;
          r.move_done   = 1'b1;
        end
      end
    end
    r.dir_a    = motion.dir_a;
    r.dir_b    = motion.dir_b;
    r.busy_res = motion.active;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Every accepted input word is predicted at once; every accepted result word
  // is compared with the oldest prediction. The push comes first, so a word
  // taken on the same edge as a result never leaves the queue short.
  always @(posedge clk_i) begin : result_check
    out_word_t want;
    out_word_t got;
    if (!rst_ni) begin
      stall_cycles = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pending_steps.push_back(predict_step(in_ch.data));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (pending_steps.size() == 0) begin
          report_mismatch($sformatf("result word %b with nothing expected", got));
        end else begin
          want = pending_steps.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (got[i] !== want[i]) begin
              report_mismatch($sformatf("%s expected %b got %b",
                                        field_names[i], want[i], got[i]));
            end
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // A hang shows up as a long stretch in which no word moves at all.
  initial begin : watchdog
    @(posedge rst_ni);
    do @(posedge clk_i); while (stall_cycles < STALL_LIMIT);
    $display("dual_axis_dda_step_generator verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Start word; the hold bit means nothing on a start, so it is random.
  function automatic in_word_t start_word(input int da, input int db, input int ivl);
    in_word_t w;
    w.func           = FUNC_START;
    w.delta_a        = da[STEP_WIDTH-1:0];
    w.delta_b        = db[STEP_WIDTH-1:0];
    w.interval_ticks = ivl[INTERVAL_WIDTH-1:0];
    w.hold           = 1'($urandom_range(1));
    return w;
  endfunction

  // Tick word; the delta and interval fields are ignored, so they are random.
  function automatic in_word_t tick_word(input bit held);
    in_word_t w;
    w.func           = FUNC_TICK;
    w.delta_a        = STEP_WIDTH'($urandom);
    w.delta_b        = STEP_WIDTH'($urandom);
    w.interval_ticks = INTERVAL_WIDTH'($urandom);
    w.hold           = held;
    return w;
  endfunction

  // Drives one word from the falling edge and returns at the rising edge that
  // accepts it. Idle cycles before it are drawn at the phase's rate. Valid is
  // assigned once per falling edge, so back-to-back words never glitch.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
  endtask

  // Holds the input side quiet until every predicted result has come back.
  task automatic drain_results;
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_steps.size() != 0) @(posedge clk_i);
  endtask

  // Sends exactly the ticks that bring any running move to its end. Once the
  // results are drained, the predicted state is settled and can be read.
  task automatic finish_move;
    int left;
    drain_results();
    if (motion.active) begin
      left = (int'(motion.span) - int'(motion.steps) - 1) * int'(motion.period)
             + int'(motion.wait_cnt) + 1;
      repeat (left) send_word(tick_word(1'b0));
    end
  endtask

  // Mostly short moves, a few longer ones, either direction.
  function automatic int pick_delta();
    int m;
    case ($urandom_range(19))
      0:                      m = $urandom_range(200);
      1, 2, 3, 4, 5, 6, 7, 8: m = $urandom_range(40);
      default:                m = $urandom_range(8);
    endcase
    return $urandom_range(1) ? -m : m;
  endfunction

  // Long intervals only go with one-step moves, which end on the first tick.
  function automatic int pick_interval(input int span);
    if (span <= 1 && $urandom_range(3) == 0) begin
      return $urandom_range((1 << INTERVAL_WIDTH) - 1);
    end
    if (span > 40) begin
      return $urandom_range(2);
    end
    case ($urandom_range(9))
      0:             return $urandom_range(7, 12);
      1, 2, 3:       return $urandom_range(3, 6);
      default:       return $urandom_range(2);
    endcase
  endfunction

  // Random traffic: mostly complete moves (start, then the ticks the move
  // needs, with held ticks mixed in), plus stray words and moves cut short.
  // A cut-short move leaves the block busy, so the next start is refused and
  // its ticks finish the older move instead.
  task automatic run_moves(input int n_words);
    int stop_at;
    int da;
    int db;
    int span;
    int ivl;
    int ticks;
    stop_at = words_sent + n_words;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 8) begin
        if ($urandom_range(1)) begin
          send_word(tick_word(1'($urandom_range(1))));
        end else begin
          send_word(start_word(0, 0, $urandom));
        end
      end else begin
        da   = pick_delta();
        db   = pick_delta();
        span = ((da < 0) ? -da : da) > ((db < 0) ? -db : db) ?
               ((da < 0) ? -da : da) : ((db < 0) ? -db : db);
        ivl  = pick_interval(span);
        send_word(start_word(da, db, ivl));
        // Right after a start with work to do the block is surely busy, so a
        // start with wild fields here is refused and cannot launch a huge move.
        if (span != 0 && $urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 2)) send_word(start_word($urandom, $urandom, $urandom));
        end
        ticks = (span == 0) ? 0 : (span - 1) * ((ivl == 0) ? 1 : ivl) + 1;
        if ($urandom_range(99) < 10) begin
          ticks = $urandom_range(ticks);
        end
        ticks += $urandom_range(2);
        while (ticks > 0) begin
          if ($urandom_range(99) < 8) begin
            send_word(tick_word(1'b1));
          end else begin
            send_word(tick_word(1'b0));
            ticks--;
          end
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked words: idle ticks with and without hold, an empty start, a
  // refused start, a held tick mid-move, a longest interval on a one-step move,
  // an empty start that must keep a reverse direction, and a spaced move.
  task automatic test_directed;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_word(tick_word(1'b0));
    send_word(tick_word(1'b1));
    send_word(start_word(0, 0, 5));
    send_word(start_word(3, -2, 0));
    send_word(start_word($urandom, $urandom, $urandom));
    send_word(tick_word(1'b0));
    send_word(tick_word(1'b1));
    send_word(tick_word(1'b0));
    send_word(tick_word(1'b0));
    send_word(tick_word(1'b0));
    send_word(start_word(-1, 0, (1 << INTERVAL_WIDTH) - 1));
    send_word(tick_word(1'b0));
    send_word(start_word(0, 0, 0));
    send_word(start_word(0, 5, 2));
    repeat (10) send_word(tick_word(1'b0));
  endtask

  task automatic test_streaming;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_moves(330);
  endtask

  task automatic test_sender_gaps;
    send_idle_pct  = 46;
    recv_stall_pct = 0;
    run_moves(330);
  endtask

  task automatic test_receiver_stalls;
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    run_moves(330);
  endtask

  task automatic test_both_idle;
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    run_moves(300);
  endtask

  // The sender stops until every result is back, then resumes mid-traffic.
  task automatic test_drain_pause;
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    repeat (3) begin
      run_moves(25);
      drain_results();
    end
  endtask

  // Extreme deltas: the most negative count on A and the most positive on B,
  // with interval 0. The accumulators then run near the top of their range.
  // The move lasts far longer than the run, so it is still busy at the end.
  task automatic test_long_move;
    send_idle_pct  = 0;
    recv_stall_pct = 18;
    finish_move();
    send_word(start_word(-(1 << (STEP_WIDTH - 1)), (1 << (STEP_WIDTH - 1)) - 1, 0));
    send_word(start_word($urandom, $urandom, $urandom));
    repeat (50) send_word(tick_word($urandom_range(99) < 15));
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    reset_motion();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_drain_pause();
    test_long_move();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("dual_axis_dda_step_generator verification clean");
    end else begin
      $display("dual_axis_dda_step_generator verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/dads_pkg.sv
src/dads_if.sv
src/dads_core.sv
src/dads_out_reg.sv
src/dual_axis_dda_step_generator.sv
src/dads_checker.sv
tb/tb_top.sv
